@@ rtl/bhp_pkg.sv @@
// Shared types, codes and byte positions for the BMP header parser.
package bhp_pkg;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_SHORT  = 2'd2,
		STATUS_UNSUP  = 2'd3
	} status_t;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	localparam logic [31:0] HDR_OS2 = 32'd12;
	localparam logic [31:0] HDR_WIN = 32'd40;

	localparam logic [15:0] MAX_WIDTH_RST = 16'd8192;

	localparam int POS_W = 6;
	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_MAGIC_B   = 6'd0;
	localparam pos_t POS_MAGIC_M   = 6'd1;
	localparam pos_t POS_OFFSET    = 6'd10;
	localparam pos_t POS_OFFSET_HI = 6'd13;
	localparam pos_t POS_SIZE      = 6'd14;
	localparam pos_t POS_SIZE_HI   = 6'd17;
	localparam pos_t POS_FIELDS    = 6'd18;
	// OS/2 core header layout
	localparam pos_t POS_O_WID_HI  = 6'd19;
	localparam pos_t POS_O_HGT     = 6'd20;
	localparam pos_t POS_O_HGT_HI  = 6'd21;
	localparam pos_t POS_O_PLN     = 6'd22;
	localparam pos_t POS_O_PLN_HI  = 6'd23;
	localparam pos_t POS_O_DEP     = 6'd24;
	localparam pos_t POS_O_END     = 6'd25;
	// Windows info header layout
	localparam pos_t POS_W_WID_HI  = 6'd21;
	localparam pos_t POS_W_HGT     = 6'd22;
	localparam pos_t POS_W_HGT_HI  = 6'd25;
	localparam pos_t POS_W_PLN     = 6'd26;
	localparam pos_t POS_W_PLN_HI  = 6'd27;
	localparam pos_t POS_W_DEP     = 6'd28;
	localparam pos_t POS_W_DEP_HI  = 6'd29;
	localparam pos_t POS_W_CMP     = 6'd30;
	localparam pos_t POS_W_CMP_HI  = 6'd33;
	localparam pos_t POS_W_XRES    = 6'd38;
	localparam pos_t POS_W_XRES_HI = 6'd41;
	localparam pos_t POS_W_YRES    = 6'd42;
	localparam pos_t POS_W_YRES_HI = 6'd45;
	localparam pos_t POS_W_END     = 6'd53;
	localparam pos_t POS_LAST      = 6'd63;

	typedef struct packed {
		logic [31:0] size;
		logic [31:0] offset;
		logic [31:0] width;
		logic [31:0] height;
		logic [15:0] planes;
		logic [15:0] depth;
		logic [31:0] compress;
		logic [31:0] xres;
		logic [31:0] yres;
	} hdr_words_t;

	typedef struct packed {
		status_t            status;
		logic               header_kind;
		logic [4:0]         bits_per_pixel;
		logic signed [31:0] image_width;
		logic signed [31:0] image_height;
		logic [30:0]        x_resolution;
		logic [30:0]        y_resolution;
		logic [31:0]        data_offset;
		logic [31:0]        compression;
	} result_t;

endpackage

@@ rtl/bhp_check.sv @@
// Final header checks and result formatting for a complete header.
module bhp_check (
	input  bhp_pkg::hdr_words_t words,
	input  logic [15:0]         max_width,
	output bhp_pkg::result_t    result
);
	import bhp_pkg::*;

	logic               depth_ok;
	logic               neg_res;
	logic               too_wide;
	logic signed [32:0] wid_ext;
	logic signed [32:0] max_ext;

	assign wid_ext  = {words.width[31], words.width};
	assign max_ext  = {17'b0, max_width};
	assign too_wide = wid_ext > max_ext;
	assign neg_res  = words.xres[31] | words.yres[31];

	always_comb begin
		case (words.depth)
			16'd1, 16'd4, 16'd8, 16'd15, 16'd16, 16'd24: depth_ok = 1'b1;
			default:                                    depth_ok = 1'b0;
		endcase
	end

	always_comb begin
		result = '0;
		if (neg_res) begin
			result.status = STATUS_FORMAT;
		end else if (words.planes != 16'd1 || too_wide || !depth_ok) begin
			result.status = STATUS_UNSUP;
		end else begin
			result.status         = STATUS_OK;
			result.header_kind    = (words.size == HDR_WIN);
			result.bits_per_pixel = words.depth[4:0];
			result.image_width    = words.width;
			result.image_height   = words.height;
			result.x_resolution   = words.xres[30:0];
			result.y_resolution   = words.yres[30:0];
			result.data_offset    = words.offset;
			result.compression    = words.compress;
		end
	end

endmodule

@@ rtl/bhp_parser.sv @@
// Byte position tracking, field assembly and per-file state.
module bhp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              end_of_file,
	input  logic [15:0]       max_width,
	output logic              res_hit,
	output bhp_pkg::result_t  result
);
	import bhp_pkg::*;

	pos_t       pos_q;
	logic       sent_q;
	hdr_words_t words_q;
	hdr_words_t nxt;
	logic       final_hit;
	status_t    err_status;
	result_t    final_res;

	function automatic logic [1:0] lane(input pos_t p, input pos_t base);
		pos_t diff;
		diff = p - base;
		return diff[1:0];
	endfunction

	function automatic logic [31:0] lane_put(input logic [31:0] w, input logic [1:0] ln,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[{ln, 3'b000} +: 8] = b;
		return r;
	endfunction

	always_comb begin
		nxt        = words_q;
		res_hit    = 1'b0;
		final_hit  = 1'b0;
		err_status = STATUS_FORMAT;
		if (!sent_q) begin
			if (pos_q == POS_MAGIC_B) begin
				res_hit = (data_byte != MAGIC_B);
			end else if (pos_q == POS_MAGIC_M) begin
				res_hit = (data_byte != MAGIC_M);
			end else if (pos_q >= POS_OFFSET && pos_q <= POS_OFFSET_HI) begin
				nxt.offset = lane_put(words_q.offset, lane(pos_q, POS_OFFSET), data_byte);
			end else if (pos_q >= POS_SIZE && pos_q <= POS_SIZE_HI) begin
				nxt.size = lane_put(words_q.size, lane(pos_q, POS_SIZE), data_byte);
				res_hit  = (pos_q == POS_SIZE_HI) && nxt.size != HDR_OS2 && nxt.size != HDR_WIN;
			end else if (pos_q >= POS_FIELDS && words_q.size == HDR_OS2) begin
				if (pos_q <= POS_O_WID_HI) begin
					nxt.width = lane_put(words_q.width, lane(pos_q, POS_FIELDS), data_byte);
				end else if (pos_q <= POS_O_HGT_HI) begin
					nxt.height = lane_put(words_q.height, lane(pos_q, POS_O_HGT), data_byte);
				end else if (pos_q <= POS_O_PLN_HI) begin
					nxt.planes = pos_q[0] ? {data_byte, words_q.planes[7:0]}
						: {words_q.planes[15:8], data_byte};
				end else if (pos_q <= POS_O_END) begin
					nxt.depth = pos_q[0] ? {data_byte, words_q.depth[7:0]}
						: {words_q.depth[15:8], data_byte};
				end
				final_hit = (pos_q >= POS_O_END);
			end else if (pos_q >= POS_FIELDS) begin
				if (pos_q <= POS_W_WID_HI) begin
					nxt.width = lane_put(words_q.width, lane(pos_q, POS_FIELDS), data_byte);
				end else if (pos_q <= POS_W_HGT_HI) begin
					nxt.height = lane_put(words_q.height, lane(pos_q, POS_W_HGT), data_byte);
				end else if (pos_q <= POS_W_PLN_HI) begin
					nxt.planes = pos_q[0] ? {data_byte, words_q.planes[7:0]}
						: {words_q.planes[15:8], data_byte};
				end else if (pos_q <= POS_W_DEP_HI) begin
					nxt.depth = pos_q[0] ? {data_byte, words_q.depth[7:0]}
						: {words_q.depth[15:8], data_byte};
				end else if (pos_q <= POS_W_CMP_HI) begin
					nxt.compress = lane_put(words_q.compress, lane(pos_q, POS_W_CMP), data_byte);
				end else if (pos_q >= POS_W_XRES && pos_q <= POS_W_XRES_HI) begin
					nxt.xres = lane_put(words_q.xres, lane(pos_q, POS_W_XRES), data_byte);
				end else if (pos_q >= POS_W_YRES && pos_q <= POS_W_YRES_HI) begin
					nxt.yres = lane_put(words_q.yres, lane(pos_q, POS_W_YRES), data_byte);
				end
				final_hit = (pos_q >= POS_W_END);
			end
			if (final_hit) begin
				res_hit = 1'b1;
			end else if (!res_hit && end_of_file) begin
				// early end: before the size field is whole the type is unconfirmed
				res_hit    = 1'b1;
				err_status = (pos_q < POS_SIZE_HI) ? STATUS_FORMAT : STATUS_SHORT;
			end
		end
	end

	bhp_check u_check (
		.words     (nxt),
		.max_width (max_width),
		.result    (final_res)
	);

	always_comb begin
		if (final_hit) begin
			result = final_res;
		end else begin
			result        = '0;
			result.status = err_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sent_q  <= 1'b0;
			words_q <= '0;
		end else if (step) begin
			if (end_of_file) begin
				pos_q   <= '0;
				sent_q  <= 1'b0;
				words_q <= '0;
			end else if (!sent_q) begin
				words_q <= nxt;
				if (res_hit) begin
					sent_q <= 1'b1;
				end else if (pos_q != POS_LAST) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/bmp_header_parser_top.sv @@
// Top level of the BMP header parser: input stage, parser and result register.
//
//  channel   direction  handshake                 payload
//  byte      in         byte_valid / byte_stall    data_byte, end_of_file
//  result    out        result_valid / result_stall status .. compression (9 fields)
//  config    in         cfg_valid / cfg_ready      max_width
//
// One byte per cycle sustained while no held result stalls a byte. An accepted
// byte sits in the input stage register, is parsed combinationally from there,
// and any result lands in the output register as the byte steps (visible from then on).
// Reset clears the per-file state, both valid flags, and sets max_width to 8192.
// A stall on the result side only holds back a byte that itself raises a result;
// bytes that raise none keep flowing while the held result waits.
// The config port is always ready; writes are meant only while the block is idle.
module bmp_header_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	// byte request channel
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          data_byte,
	input  logic                end_of_file,
	// result request channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          status,
	output logic                header_kind,
	output logic [4:0]          bits_per_pixel,
	output logic signed [31:0]  image_width,
	output logic signed [31:0]  image_height,
	output logic [30:0]         x_resolution,
	output logic [30:0]         y_resolution,
	output logic [31:0]         data_offset,
	output logic [31:0]         compression,
	// configuration write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         max_width
);
	import bhp_pkg::*;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;

	logic [15:0] max_width_q;
	logic        res_hit;
	result_t     res;
	logic        out_free;
	logic        step;

	logic        result_valid_q;
	result_t     result_q;

	// a byte with no result never waits for the output register
	assign out_free   = !result_valid_q || !result_stall;
	assign step       = valid_s1 && (!res_hit || out_free);
	assign byte_stall = valid_s1 && !step;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= MAX_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_width_q <= max_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	bhp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.max_width   (max_width_q),
		.res_hit     (res_hit),
		.result      (res)
	);

	// result register; a new result may replace one being taken this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && res_hit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_hit) begin
			result_q <= res;
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = result_q.status;
	assign header_kind    = result_q.header_kind;
	assign bits_per_pixel = result_q.bits_per_pixel;
	assign image_width    = result_q.image_width;
	assign image_height   = result_q.image_height;
	assign x_resolution   = result_q.x_resolution;
	assign y_resolution   = result_q.y_resolution;
	assign data_offset    = result_q.data_offset;
	assign compression    = result_q.compression;

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_hit) |-> out_free)
		else $error("result register overwritten while held");

	// stall towards the source only with a byte parked in the input stage
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("byte_stall raised with empty input stage");

	// error results carry nothing but their status
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.status != STATUS_OK) |->
		(result_q.bits_per_pixel == 5'd0 && result_q.data_offset == 32'd0 &&
		 result_q.header_kind == 1'b0))
		else $error("error result with nonzero fields");

	// a good header always reports a nonzero depth
	a_ok_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.status == STATUS_OK) |->
		(result_q.bits_per_pixel != 5'd0))
		else $error("ok result with zero depth");

endmodule
